// File: hw/rtl/dequ_pkg.sv
// Shared types and constants for the double-ended queue unit.
package dequ_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int CMD_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_IDX   = 3'd4,
    CMD_WRITE_IDX  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Decoded memory access and outcome of one command.
  typedef struct packed {
    logic    rd;
    logic    wr;
    status_e status;
  } op_t;

endpackage

// File: hw/rtl/dequ_ram.sv
// Single-port element store with a registered read port.
module dequ_ram #(
  parameter int Depth  = 1024,
  parameter int AddrW  = 10,
  parameter int DataW  = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dequ_ctrl.sv
// Head pointer and element count, command decode and slot address generation.
module dequ_ctrl #(
  parameter int Depth = 1024,
  parameter int PtrW  = 10,
  parameter int CntW  = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [dequ_pkg::CMD_W-1:0]      cmd_i,
  input  logic [dequ_pkg::POS_W-1:0]      pos_i,
  output dequ_pkg::op_t                   op_o,
  output logic [PtrW-1:0]                 slot_o,
  output logic [CntW-1:0]                 count_o
);

  localparam int SumW = PtrW + 1;
  localparam int CmpW = (CntW > dequ_pkg::POS_W) ? CntW : dequ_pkg::POS_W;
  localparam logic [SumW-1:0] DepthS   = SumW'(Depth);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] head_dec, head_inc, slot_cnt, slot_last, slot_pos;
  logic [CntW-1:0] count_dec;
  logic            full, empty, in_range;
  dequ_pkg::op_t   op;
  logic [PtrW-1:0] slot;

  // Offsets handed in here are always below Depth when the result is used,
  // so one conditional subtract brings the sum back into range.
  function automatic logic [PtrW-1:0] slot_of(logic [PtrW-1:0] head,
                                              logic [SumW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + off;
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[PtrW-1:0];
  endfunction

  assign count_dec = count_q - CntW'(1);
  assign head_dec  = (head_q == '0) ? LastSlot : head_q - PtrW'(1);
  assign head_inc  = (head_q == LastSlot) ? '0 : head_q + PtrW'(1);
  assign slot_cnt  = slot_of(head_q, SumW'(count_q));
  assign slot_last = slot_of(head_q, SumW'(count_dec));
  assign slot_pos  = slot_of(head_q, SumW'(pos_i));
  assign full      = (count_q == FullCnt);
  assign empty     = (count_q == '0);
  assign in_range  = (CmpW'(pos_i) < CmpW'(count_q));

  always_comb begin
    op        = '{rd: 1'b0, wr: 1'b0, status: dequ_pkg::ST_OK};
    slot      = head_q;
    head_d    = head_q;
    count_d   = count_q;
    unique case (dequ_pkg::cmd_e'(cmd_i))
      dequ_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          op.status = dequ_pkg::ST_FULL;
        end else begin
          op.wr   = 1'b1;
          slot    = head_dec;
          head_d  = head_dec;
          count_d = count_q + CntW'(1);
        end
      end
      dequ_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          op.status = dequ_pkg::ST_FULL;
        end else begin
          op.wr   = 1'b1;
          slot    = slot_cnt;
          count_d = count_q + CntW'(1);
        end
      end
      dequ_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          op.status = dequ_pkg::ST_EMPTY;
        end else begin
          op.rd   = 1'b1;
          slot    = head_q;
          head_d  = head_inc;
          count_d = count_dec;
        end
      end
      dequ_pkg::CMD_POP_BACK: begin
        if (empty) begin
          op.status = dequ_pkg::ST_EMPTY;
        end else begin
          op.rd   = 1'b1;
          slot    = slot_last;
          count_d = count_dec;
        end
      end
      dequ_pkg::CMD_READ_IDX: begin
        if (!in_range) begin
          op.status = dequ_pkg::ST_RANGE;
        end else begin
          op.rd = 1'b1;
          slot  = slot_pos;
        end
      end
      dequ_pkg::CMD_WRITE_IDX: begin
        if (!in_range) begin
          op.status = dequ_pkg::ST_RANGE;
        end else begin
          op.wr = 1'b1;
          slot  = slot_pos;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  assign op_o    = op;
  assign slot_o  = slot;
  assign count_o = count_q;

endmodule

// File: hw/rtl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit words held in a circular on-chip store.
//
// Usage: a command beat on the input channel (command_i, position_i,
// data_in_i) pushes or pops at either end, or reads or writes the element
// at position_i counted from the front. Each command yields exactly one
// result beat (data_out_o, status_o, length_o) on the output channel.
// Failing commands (push on full, pop on empty, position beyond the length)
// leave the queue unchanged and return a nonzero status with zero data.
// Unused command codes return status ok, zero data and the current length.
//
// Timing: a command is taken and the store's registered read port is loaded
// at the same edge; the result beat is registered from it in state S_RESP.
// One command is handled at a time, so no new command is taken while the
// unit is in S_RESP, before the previous result beat is registered.
// A new command may be taken while the previous result still waits,
// provided that result is taken in the same cycle.
// Reset leaves the queue empty; the store needs no clearing pass since only
// written entries are ever read. A stalled receiver holds off new commands.
module double_ended_queue_unit #(
  parameter int DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dequ_pkg::CMD_W-1:0]           command_i,
  input  logic [dequ_pkg::POS_W-1:0]           position_i,
  input  logic signed [dequ_pkg::DATA_W-1:0]   data_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dequ_pkg::DATA_W-1:0]   data_out_o,
  output logic [1:0]                           status_o,
  output logic [dequ_pkg::LEN_W-1:0]           length_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int ExtW = CntW + dequ_pkg::LEN_W;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e                        state_q;
  logic                          accept;
  dequ_pkg::op_t                 op;
  logic [PtrW-1:0]               slot;
  logic [CntW-1:0]               count;
  logic [ExtW-1:0]               count_ext;
  logic [dequ_pkg::DATA_W-1:0]   rdata;
  logic                          rd_q;
  dequ_pkg::status_e             status_q;
  logic                          out_valid_q;
  logic [dequ_pkg::DATA_W-1:0]   out_data_q;
  logic [1:0]                    out_status_q;
  logic [dequ_pkg::LEN_W-1:0]    out_len_q;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  dequ_ctrl #(
    .Depth (DEPTH),
    .PtrW  (PtrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (command_i),
    .pos_i    (position_i),
    .op_o     (op),
    .slot_o   (slot),
    .count_o  (count)
  );

  dequ_ram #(
    .Depth (DEPTH),
    .AddrW (PtrW),
    .DataW (dequ_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && op.wr),
    .re_i    (accept && op.rd),
    .addr_i  (slot),
    .wdata_i (data_in_i),
    .rdata_o (rdata)
  );

  // The length output carries the element count masked to its port width.
  assign count_ext = ExtW'(count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= '0;
      out_len_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          state_q      <= S_IDLE;
          out_valid_q  <= 1'b1;
          out_data_q   <= rd_q ? rdata : '0;
          out_status_q <= status_q;
          out_len_q    <= count_ext[dequ_pkg::LEN_W-1:0];
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= op.rd;
      status_q <= op.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;
  assign status_o    = out_status_q;
  assign length_o    = out_len_q;

endmodule

// File: test/deque_checker.sv
// Checker that predicts each deque result and compares it with the result beats.
module deque_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [dequ_pkg::CMD_W-1:0]           command_i,
  input  logic [dequ_pkg::POS_W-1:0]           position_i,
  input  logic signed [dequ_pkg::DATA_W-1:0]   data_in_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [dequ_pkg::DATA_W-1:0]   data_out_i,
  input  logic [1:0]                           status_i,
  input  logic [dequ_pkg::LEN_W-1:0]           length_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dequ_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [LEN_W-1:0]         len;
  } deque_result_t;

  logic signed [DATA_W-1:0] slots [DEPTH];
  int unsigned head_slot;
  int unsigned stored;
  int mismatches;
  deque_result_t pending_results [$];

  function automatic int unsigned slot_at(int unsigned offset);
    return (head_slot + offset) % DEPTH;
  endfunction

  // Applies one command to the shadow deque and queues the result it must produce.
  task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] din);
    deque_result_t res;
    res.data   = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (stored >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
          slots[head_slot] = din;
          stored++;
        end
      end
      CMD_PUSH_BACK: begin
        if (stored >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slots[slot_at(stored)] = din;
          stored++;
        end
      end
      CMD_POP_FRONT: begin
        if (stored == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = slots[head_slot];
          head_slot = slot_at(1);
          stored--;
        end
      end
      CMD_POP_BACK: begin
        if (stored == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = slots[slot_at(stored - 1)];
          stored--;
        end
      end
      CMD_READ_IDX: begin
        if (pos >= stored) begin
          res.status = ST_RANGE;
        end else begin
          res.data = slots[slot_at(pos)];
        end
      end
      CMD_WRITE_IDX: begin
        if (pos >= stored) begin
          res.status = ST_RANGE;
        end else begin
          slots[slot_at(pos)] = din;
        end
      end
      default: begin
      end
    endcase
    res.len = LEN_W'(stored);
    pending_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    deque_result_t want;
    if (!rst_ni) begin
      head_slot = 0;
      stored = 0;
      mismatches = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // The result beat of this edge always belongs to an older command.
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, data_out %0d status %0d length %0d",
                   $time, data_out_i, status_i, length_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (data_out_i !== want.data) begin
            $display("%0t: data_out expected %0d, got %0d", $time, want.data, data_out_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            mismatches++;
          end
          if (length_i !== want.len) begin
            $display("%0t: length expected %0d, got %0d", $time, want.len, length_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_command(command_i, position_i, data_in_i);
      end
      fail_count_o <= mismatches;
      pending_o <= pending_results.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top: drives command beats into the deque unit and reports the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dequ_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 100;

  // Command codes the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         command_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] data_in_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] data_out_o;
  logic [1:0]               status_o;
  logic [LEN_W-1:0]         length_o;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  int queued;
  logic hold_req;

  double_ended_queue_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .position_i (position_i),
    .data_in_i  (data_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .length_o   (length_o)
  );

  deque_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_i  (data_out_o),
    .status_i    (status_o),
    .length_i    (length_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one command beat and returns at the edge where it is taken.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    data_in_i  <= din;
    do @(posedge clk_i); while (!in_ready_o);
    // Keep a running length so positions can be aimed inside the stored range.
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (queued < DEPTH) queued++;
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (queued > 0) queued--;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_random(input int push_pct, input int pop_pct);
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    pick = $urandom_range(99);
    pos = POS_W'($urandom);
    if (pick < push_pct) begin
      cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (pick < push_pct + pop_pct) begin
      cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else if (pick < 97) begin
      cmd = $urandom_range(1) ? CMD_WRITE_IDX : CMD_READ_IDX;
      if (queued > 0 && $urandom_range(9) != 0) pos = POS_W'($urandom_range(queued - 1));
    end else begin
      cmd = $urandom_range(1) ? CMD_UNUSED_B : CMD_UNUSED_A;
    end
    send_cmd(cmd, pos, random_word());
  endtask

  // The pending count is registered in the checker, so wait for a clock edge before checking it.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_valid_i = 1'b0;
    command_i = CMD_PUSH_FRONT;
    position_i = '0;
    data_in_i = '0;
    rst_ni = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    queued = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-queue failures, unused codes, extreme values and index bounds.
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_READ_IDX, '0, '0);
    send_cmd(CMD_WRITE_IDX, '0, 32'sh1234_5678);
    send_cmd(CMD_UNUSED_A, '0, '1);
    send_cmd(CMD_UNUSED_B, '1, '1);
    send_cmd(CMD_PUSH_FRONT, '0, 32'sh7fff_ffff);
    send_cmd(CMD_PUSH_BACK, '0, 32'sh8000_0000);
    send_cmd(CMD_PUSH_FRONT, '0, '0);
    send_cmd(CMD_PUSH_BACK, '0, '1);
    for (int i = 0; i < 4; i++) send_cmd(CMD_READ_IDX, POS_W'(i), '0);
    send_cmd(CMD_READ_IDX, 10'd4, '0);
    send_cmd(CMD_WRITE_IDX, '1, 32'sh0bad_cafe);
    send_cmd(CMD_READ_IDX, '1, '0);
    send_cmd(CMD_WRITE_IDX, 10'd2, 32'sh5a5a_5a5a);
    send_cmd(CMD_READ_IDX, 10'd2, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    wait_for_results();

    // Mixed traffic under each idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Back up the result side while commands keep coming.
        if (phase == 0 && n == 30) hold_req = 1'b1;
        send_random(40, 35);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dequ_pkg.sv
hw/rtl/dequ_ram.sv
hw/rtl/dequ_ctrl.sv
hw/rtl/double_ended_queue_unit.sv
test/deque_checker.sv
test/tb_top.sv
